/* src/jhsv_pkg.sv */
`timescale 1ns / 1ps
// jhsv_pkg: widths and constants for the joystick hsv to rgb color block
// no dependencies; used by the channel interfaces and the top level

package jhsv_pkg;

  // joystick sample width default
  localparam int ADC_BITS_DEF = 10;

  // field widths
  localparam int DT_W     = 16;
  localparam int HUE_W    = 19;
  localparam int BRIGHT_W = 19;
  localparam int SAT_W    = 9;
  localparam int CHAN_W   = 8;

  // hue and brightness scales
  localparam int                  SECTOR_N     = 61440;
  localparam int                  NUM_SECTORS  = 6;
  localparam logic [15:0]         SECTOR       = 16'd61440;
  localparam logic [HUE_W-1:0]    HUE_FULL     = 19'd368640;
  localparam logic [HUE_W-1:0]    HUE_RESET    = 19'd184320;
  localparam logic [BRIGHT_W-1:0] BRIGHT_FULL  = 19'd368640;
  localparam logic [BRIGHT_W-1:0] BRIGHT_RESET = 19'd36864;
  localparam logic [SAT_W-1:0]    SAT_FULL     = 9'd256;

  // deadzone: step counts when |d| / 2^ADC_BITS > 7/100
  localparam int STEP_NUM = 7;
  localparam int STEP_DEN = 100;

  // step magnitude in hue units
  localparam int MAG_W = 25;

  // shared multiplier operand and product widths
  localparam int MUL_A_W = 24;
  localparam int MUL_B_W = 19;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // channel scaling: floor(255 * v * w / (2^33 * 675))
  localparam logic [MUL_A_W-1:0] W_FULL      = 24'd15728640;
  localparam int                 SCALE_SHIFT = 33;
  localparam int                 Y_W         = 18;
  localparam logic [Y_W-1:0]     DEN_ODD     = 18'd675;
  localparam logic [MUL_B_W-1:0] RECIP       = 19'd397682;
  localparam int                 RECIP_SHIFT = 28;

endpackage

/* src/jhsv_if.sv */
`timescale 1ns / 1ps
// jhsv channel interfaces: joystick word, color word and saturation write
// depends on jhsv_pkg for field widths

interface jhsv_joy_if #(parameter int ADC_BITS = jhsv_pkg::ADC_BITS_DEF);
  import jhsv_pkg::*;
  logic                valid;
  logic                ready;
  logic [DT_W-1:0]     elapsed_ms;
  logic [ADC_BITS-1:0] stick_x;
  logic [ADC_BITS-1:0] stick_y;
  modport source (output valid, elapsed_ms, stick_x, stick_y, input ready);
  modport sink (input valid, elapsed_ms, stick_x, stick_y, output ready);
endinterface

interface jhsv_color_if;
  import jhsv_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;
  logic [HUE_W-1:0]  hue_now;
  modport source (output valid, red, green, blue, hue_now, input ready);
  modport sink (input valid, red, green, blue, hue_now, output ready);
endinterface

interface jhsv_cfg_if;
  import jhsv_pkg::*;
  logic             valid;
  logic             ready;
  logic [SAT_W-1:0] saturation;
  modport source (output valid, saturation, input ready);
  modport sink (input valid, saturation, output ready);
endinterface

/* src/joystick_hsv_to_rgb_led_color.sv */
`timescale 1ns / 1ps
// joystick_hsv_to_rgb_led_color: joystick-steered hue/brightness with hsv to rgb
// depends on jhsv_pkg and the channel interfaces in jhsv_if.sv
//
// Usage:
//   joy   - input word: elapsed_ms and two joystick samples (center 2^(ADC_BITS-1)).
//           stick_x turns the hue, stick_y lowers the brightness; small steps
//           fall in the deadzone.
//   color - result word: red, green, blue duty (floor of 255 * channel) and the
//           updated hue, one word for every joy word.
//   cfg   - saturation write (256 means full); always ready, write it while idle.
// Timing:
//   joy.ready is high only while the sequencer is idle, so a joy word is not
//   taken before the last one is through. The result of a joy word is loaded
//   into the output register from ST_DONE, and the next joy word can be taken
//   on the cycle after that. The pace is set by one shared 24x19 multiplier
//   that is used nine times per word (two step products, saturation times
//   sector offset, and a scale and a reciprocal product for each of three colors).
// Reset (rst, synchronous): hue 180 degrees, brightness 0.1, saturation 1.0,
//   no result pending.
// Stall: a finished result waits in the output register while the next joy
//   word is worked on; a second result waits in the sequencer until taken.

module joystick_hsv_to_rgb_led_color #(
  parameter int ADC_BITS = jhsv_pkg::ADC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  jhsv_joy_if.sink     joy,
  jhsv_color_if.source color,
  jhsv_cfg_if.sink     cfg
);
  import jhsv_pkg::*;

  // step scaling derived from the sample width
  localparam logic [ADC_BITS-1:0] CENTER = ADC_BITS'(1 << (ADC_BITS - 1));
  localparam int RAW_W  = DT_W + ADC_BITS - 1;
  localparam int SHL    = (ADC_BITS <= 10) ? (10 - ADC_BITS) : 0;
  localparam int SHR    = (ADC_BITS > 10) ? (ADC_BITS - 10) : 0;
  localparam int WIDE_W = RAW_W + SHL;
  localparam logic [RAW_W-1:0] THRESH = RAW_W'((STEP_NUM << ADC_BITS) / STEP_DEN);

  // sequencer states
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_MULX = 4'd1;
  localparam logic [3:0] ST_HUE  = 4'd2;
  localparam logic [3:0] ST_BRI  = 4'd3;
  localparam logic [3:0] ST_SATT = 4'd4;
  localparam logic [3:0] ST_MV   = 4'd5;
  localparam logic [3:0] ST_SC   = 4'd6;
  localparam logic [3:0] ST_MR   = 4'd7;
  localparam logic [3:0] ST_CO   = 4'd8;
  localparam logic [3:0] ST_DONE = 4'd9;

  // color value roles: full, minimum, ramp
  localparam logic [1:0] CH_C = 2'd0;
  localparam logic [1:0] CH_M = 2'd1;
  localparam logic [1:0] CH_X = 2'd2;

  // control and state registers
  logic [3:0]          state;
  logic [1:0]          ch;
  logic [HUE_W-1:0]    hue;
  logic [BRIGHT_W-1:0] brightness;
  logic [SAT_W-1:0]    sat;
  logic                out_valid;

  // datapath registers
  logic [DT_W-1:0]     dt;
  logic [ADC_BITS-1:0] sx;
  logic [ADC_BITS-1:0] sy;
  logic [PROD_W-1:0]   prod;
  logic [2:0]          sector;
  logic [15:0]         tval;
  logic [MUL_A_W-1:0]  wx;
  logic [Y_W-1:0]      y;
  logic [CHAN_W-1:0]   qc;
  logic [CHAN_W-1:0]   qm;
  logic [CHAN_W-1:0]   qx;
  logic [CHAN_W-1:0]   out_red;
  logic [CHAN_W-1:0]   out_green;
  logic [CHAN_W-1:0]   out_blue;
  logic [HUE_W-1:0]    out_hue;

  // combinational signals
  logic [ADC_BITS-1:0] off_x;
  logic [ADC_BITS-1:0] off_y;
  logic                neg_x;
  logic                neg_y;
  logic [RAW_W-1:0]    raw;
  logic                counted;
  logic [WIDE_W-1:0]   raw_wide;
  logic [MAG_W-1:0]    mag;
  logic [MAG_W:0]      hue_sum;
  logic [MAG_W:0]      bri_sum;
  logic [HUE_W-1:0]    hue_next;
  logic [BRIGHT_W-1:0] brightness_next;
  logic [2:0]          sector_next;
  logic [HUE_W-1:0]    sector_base;
  logic [HUE_W-1:0]    rem_full;
  logic [15:0]         tval_next;
  logic [SAT_W-1:0]    sat_c;
  logic [SAT_W-1:0]    sat_inv;
  logic [12:0]         sat_inv15;
  logic [MUL_A_W+0:0]  wm_wide;
  logic [MUL_A_W-1:0]  wm;
  logic [MUL_A_W-1:0]  w_sel;
  logic [MUL_A_W-1:0]  mul_a;
  logic [MUL_B_W-1:0]  mul_b;
  logic [PROD_W-1:0]   mul_p;
  logic [PROD_W+7:0]   scaled;
  logic [CHAN_W-1:0]   q_est;
  logic [Y_W-1:0]      q_back;
  logic [Y_W-1:0]      q_rem;
  logic [CHAN_W-1:0]   q_fix;
  logic [CHAN_W-1:0]   red_next;
  logic [CHAN_W-1:0]   green_next;
  logic [CHAN_W-1:0]   blue_next;

  // distance of a sample from center
  function automatic logic [ADC_BITS-1:0] axis_off(input logic [ADC_BITS-1:0] s);
    axis_off = (s >= CENTER) ? (s - CENTER) : (CENTER - s);
  endfunction

  // handshakes
  assign joy.ready     = (state == ST_IDLE);
  assign cfg.ready     = 1'b1;
  assign color.valid   = out_valid;
  assign color.red     = out_red;
  assign color.green   = out_green;
  assign color.blue    = out_blue;
  assign color.hue_now = out_hue;

  // per-axis offsets and directions
  assign off_x = axis_off(sx);
  assign off_y = axis_off(sy);
  assign neg_x = (sx < CENTER);
  assign neg_y = (sy < CENTER);

  // step product in hue units, deadzone test
  assign raw      = prod[RAW_W-1:0];
  assign counted  = (raw > THRESH);
  assign raw_wide = WIDE_W'(raw) << SHL;
  assign mag      = raw_wide[WIDE_W-1:SHR];

  // hue update: out of range in either direction ends at zero
  assign hue_sum = (MAG_W + 1)'(hue) + (MAG_W + 1)'(mag);
  always_comb begin
    hue_next = hue;
    if (counted) begin
      if (neg_x) begin
        hue_next = (mag > MAG_W'(hue)) ? '0 : (hue - mag[HUE_W-1:0]);
      end else begin
        hue_next = (hue_sum >= (MAG_W + 1)'(HUE_FULL)) ? '0 : hue_sum[HUE_W-1:0];
      end
    end
  end

  // brightness update: a positive step lowers it, clamped to zero and to full scale
  assign bri_sum = (MAG_W + 1)'(brightness) + (MAG_W + 1)'(mag);
  always_comb begin
    brightness_next = brightness;
    if (counted) begin
      if (neg_y) begin
        brightness_next = (bri_sum > (MAG_W + 1)'(BRIGHT_FULL)) ?
                          BRIGHT_FULL : bri_sum[BRIGHT_W-1:0];
      end else begin
        brightness_next = (mag > MAG_W'(brightness)) ?
                          '0 : (brightness - mag[BRIGHT_W-1:0]);
      end
    end
  end

  // sector and offset within it, folded on odd sectors
  always_comb begin
    sector_next = '0;
    sector_base = '0;
    for (int k = 1; k < NUM_SECTORS; k++) begin
      if (hue >= HUE_W'(k * SECTOR_N)) begin
        sector_next = 3'(k);
        sector_base = HUE_W'(k * SECTOR_N);
      end
    end
  end
  assign rem_full  = hue - sector_base;
  assign tval_next = sector_next[0] ? (SECTOR - rem_full[15:0]) : rem_full[15:0];

  // saturation clamp and minimum weight (256 - sat) * 61440
  assign sat_c     = (sat > SAT_FULL) ? SAT_FULL : sat;
  assign sat_inv   = SAT_FULL - sat_c;
  assign sat_inv15 = {sat_inv, 4'b0000} - 13'(sat_inv);
  assign wm_wide   = {sat_inv15, 12'b0};
  assign wm        = wm_wide[MUL_A_W-1:0];

  // weight for the color value in work
  always_comb begin
    case (ch)
      CH_C:    w_sel = W_FULL;
      CH_M:    w_sel = wm;
      default: w_sel = wx;
    endcase
  end

  // shared multiplier operand select
  always_comb begin
    unique case (state)
      ST_MULX: begin
        mul_a = MUL_A_W'(dt);
        mul_b = MUL_B_W'(off_x);
      end
      ST_HUE: begin
        mul_a = MUL_A_W'(dt);
        mul_b = MUL_B_W'(off_y);
      end
      ST_SATT: begin
        mul_a = MUL_A_W'(tval);
        mul_b = MUL_B_W'(sat_c);
      end
      ST_MV: begin
        mul_a = w_sel;
        mul_b = brightness;
      end
      ST_MR: begin
        mul_a = MUL_A_W'(y);
        mul_b = RECIP;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // scale by 255, then divide by 675 through the reciprocal with one correction
  assign scaled = {prod, 8'b0} - (PROD_W + 8)'(prod);
  assign q_est  = prod[RECIP_SHIFT+CHAN_W-1:RECIP_SHIFT];
  assign q_back = Y_W'(q_est) * DEN_ODD;
  assign q_rem  = y - q_back;
  assign q_fix  = q_est + CHAN_W'(q_rem >= DEN_ODD);

  // sector to channel routing
  always_comb begin
    case (sector)
      3'd0: begin red_next = qc; green_next = qx; blue_next = qm; end
      3'd1: begin red_next = qx; green_next = qc; blue_next = qm; end
      3'd2: begin red_next = qm; green_next = qc; blue_next = qx; end
      3'd3: begin red_next = qm; green_next = qx; blue_next = qc; end
      3'd4: begin red_next = qx; green_next = qm; blue_next = qc; end
      default: begin red_next = qc; green_next = qm; blue_next = qx; end
    endcase
  end

  // sequencer, hue/brightness/saturation state, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      ch         <= CH_C;
      hue        <= HUE_RESET;
      brightness <= BRIGHT_RESET;
      sat        <= SAT_FULL;
      out_valid  <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        sat <= cfg.saturation;
      end
      // result register: load on the final step, clear when taken
      if (state == ST_DONE && (!out_valid || color.ready)) begin
        out_valid <= 1'b1;
      end else if (color.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (joy.valid) begin
            state <= ST_MULX;
          end
        end
        ST_MULX: state <= ST_HUE;
        ST_HUE: begin
          hue   <= hue_next;
          state <= ST_BRI;
        end
        ST_BRI: begin
          brightness <= brightness_next;
          state      <= ST_SATT;
        end
        ST_SATT: begin
          ch    <= CH_C;
          state <= ST_MV;
        end
        ST_MV: state <= ST_SC;
        ST_SC: state <= ST_MR;
        ST_MR: state <= ST_CO;
        ST_CO: begin
          if (ch == CH_X) begin
            state <= ST_DONE;
          end else begin
            ch    <= ch + 2'd1;
            state <= ST_MV;
          end
        end
        ST_DONE: begin
          if (!out_valid || color.ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod <= mul_p;
    if (joy.valid && joy.ready) begin
      dt <= joy.elapsed_ms;
      sx <= joy.stick_x;
      sy <= joy.stick_y;
    end
    if (state == ST_BRI) begin
      sector <= sector_next;
      tval   <= tval_next;
    end
    if (state == ST_MV && ch == CH_C) begin
      wx <= prod[MUL_A_W-1:0] + wm;
    end
    if (state == ST_SC) begin
      y <= scaled[SCALE_SHIFT+Y_W-1:SCALE_SHIFT];
    end
    if (state == ST_CO) begin
      case (ch)
        CH_C:    qc <= q_fix;
        CH_M:    qm <= q_fix;
        default: qx <= q_fix;
      endcase
    end
    if (state == ST_DONE && (!out_valid || color.ready)) begin
      out_red   <= red_next;
      out_green <= green_next;
      out_blue  <= blue_next;
      out_hue   <= hue;
    end
  end

`ifndef SYNTHESIS
  // hue always stays below a full turn
  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    hue < HUE_FULL) else $error("hue out of range");

  // brightness never exceeds full scale
  a_bri_range: assert property (@(posedge clk) disable iff (rst)
    brightness <= BRIGHT_FULL) else $error("brightness out of range");

  // a taken joy word blocks the next one
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    joy.valid && joy.ready |=> !joy.ready) else $error("joy taken while busy");

  // a new result only comes out of the final sequencer step
  a_valid_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_DONE) else $error("result out of sequence");
`endif

endmodule

/* dv/joystick_hsv_to_rgb_led_color_tb.sv */
`timescale 1ns / 1ps
// testbench for joystick_hsv_to_rgb_led_color: random and directed joystick words,
// each color word checked against an in-bench hue/brightness tracker
// depends on jhsv_pkg, the channel interfaces in jhsv_if.sv and the top level

module joystick_hsv_to_rgb_led_color_tb;
  import jhsv_pkg::*;

  localparam int              STICK_W    = ADC_BITS_DEF;
  localparam int              STICK_MID  = 1 << (STICK_W - 1);
  localparam longint unsigned SAT_ONE    = SAT_FULL;
  localparam longint unsigned BRIGHT_ONE = BRIGHT_FULL;
  localparam longint unsigned HUE_ONE    = HUE_FULL;
  localparam longint unsigned SECT       = SECTOR_N;
  localparam longint unsigned COLOR_DEN  = BRIGHT_ONE * SAT_ONE * SECT;
  localparam int              PHASE_WORDS = 210;
  localparam int              NUM_PHASES  = 8;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [HUE_W-1:0]  hue_now;
  } color_t;

  // tracks hue, brightness and saturation and holds the colors still owed
  class led_color_tracker;
    longint unsigned hue;
    longint unsigned bright;
    longint unsigned sat;
    color_t          owed_colors[$];
    int              mismatches;

    function new();
      hue        = HUE_RESET;
      bright     = BRIGHT_RESET;
      sat        = SAT_FULL;
      mismatches = 0;
    endfunction

    function void set_saturation(logic [SAT_W-1:0] value);
      sat = value;
    endfunction

    function int pending();
      return owed_colors.size();
    endfunction

    // step size and direction of one stick; returns 1 outside the deadzone
    function bit stick_step(logic [DT_W-1:0] dt, logic [STICK_W-1:0] sample,
                            output longint unsigned mag, output bit neg);
      longint unsigned off;
      if (sample >= STICK_MID) begin
        off = sample - STICK_MID;
        neg = 1'b0;
      end else begin
        off = STICK_MID - sample;
        neg = 1'b1;
      end
      mag = longint'(dt) * off;
      return mag * longint'(STEP_DEN) > (longint'(STEP_NUM) << STICK_W);
    endfunction

    function logic [CHAN_W-1:0] duty(longint unsigned num);
      longint unsigned q;
      q = num * 255 / COLOR_DEN;
      return (q > 255) ? 8'd255 : q[CHAN_W-1:0];
    endfunction

    // apply one accepted joystick word and queue the color it must give
    function void take_word(logic [DT_W-1:0] dt, logic [STICK_W-1:0] sx,
                            logic [STICK_W-1:0] sy);
      longint unsigned mag, nh, nb, s, sector, rem, t, nv, nm, nx;
      bit              neg;
      color_t          c;
      // hue turns with x; any wrap ends at zero
      if (stick_step(dt, sx, mag, neg)) begin
        if (neg) begin
          hue = (mag > hue) ? 0 : hue - mag;
        end else begin
          nh  = hue + mag;
          hue = (nh >= HUE_ONE) ? 0 : nh;
        end
      end
      // positive y lowers brightness, clamped to 0..full
      if (stick_step(dt, sy, mag, neg)) begin
        if (neg) begin
          nb     = bright + mag;
          bright = (nb > BRIGHT_ONE) ? BRIGHT_ONE : nb;
        end else begin
          bright = (mag > bright) ? 0 : bright - mag;
        end
      end
      // exact hsv to rgb over BRIGHT_FULL * SAT_FULL * SECTOR
      s      = (sat > SAT_ONE) ? SAT_ONE : sat;
      sector = hue / SECT;
      rem    = hue % SECT;
      t      = (sector % 2 == 1) ? SECT - rem : rem;
      nv     = bright * SAT_ONE * SECT;
      nm     = bright * (SAT_ONE - s) * SECT;
      nx     = bright * s * t + nm;
      case (sector)
        0: begin c.red = duty(nv); c.green = duty(nx); c.blue = duty(nm); end
        1: begin c.red = duty(nx); c.green = duty(nv); c.blue = duty(nm); end
        2: begin c.red = duty(nm); c.green = duty(nv); c.blue = duty(nx); end
        3: begin c.red = duty(nm); c.green = duty(nx); c.blue = duty(nv); end
        4: begin c.red = duty(nx); c.green = duty(nm); c.blue = duty(nv); end
        default: begin c.red = duty(nv); c.green = duty(nm); c.blue = duty(nx); end
      endcase
      c.hue_now = hue[HUE_W-1:0];
      owed_colors.push_back(c);
    endfunction

    // compare one color word with the oldest one owed
    function void match_color(logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                              logic [CHAN_W-1:0] b, logic [HUE_W-1:0] h);
      color_t want;
      if (owed_colors.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: color word with none owed: r %0d g %0d b %0d hue %0d",
                   $realtime, r, g, b, h);
        mismatches++;
        return;
      end
      want = owed_colors.pop_front();
      if (r !== want.red || g !== want.green || b !== want.blue ||
          h !== want.hue_now) begin
        if (mismatches < 10)
          $display("%0t: exp r %0d g %0d b %0d hue %0d, got r %0d g %0d b %0d hue %0d",
                   $realtime, want.red, want.green, want.blue, want.hue_now,
                   r, g, b, h);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   idle_enable = 1'b1;
  int   stall_left  = 0;

  led_color_tracker tracker;

  jhsv_joy_if   joy_bus ();
  jhsv_color_if color_bus ();
  jhsv_cfg_if   cfg_bus ();

  joystick_hsv_to_rgb_led_color dut (
    .clk   (clk),
    .rst   (rst),
    .joy   (joy_bus),
    .color (color_bus),
    .cfg   (cfg_bus)
  );

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // color side: check every accepted word, stall in random bursts while idling is enabled
  always @(posedge clk) begin
    if (!rst && color_bus.valid && color_bus.ready)
      tracker.match_color(color_bus.red, color_bus.green, color_bus.blue,
                          color_bus.hue_now);
    if (stall_left == 0 && idle_enable && $urandom_range(0, 7) == 0)
      stall_left = $urandom_range(1, 10);
    if (stall_left > 0) begin
      stall_left--;
      color_bus.ready <= 1'b0;
    end else begin
      color_bus.ready <= 1'b1;
    end
  end

  // send one joystick word, sometimes with a random gap before it
  task automatic send_word(logic [DT_W-1:0] dt, logic [STICK_W-1:0] sx,
                           logic [STICK_W-1:0] sy);
    if (idle_enable && $urandom_range(0, 5) == 0) begin
      joy_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    joy_bus.valid      <= 1'b1;
    joy_bus.elapsed_ms <= dt;
    joy_bus.stick_x    <= sx;
    joy_bus.stick_y    <= sy;
    do @(posedge clk); while (!joy_bus.ready);
    tracker.take_word(dt, sx, sy);
  endtask

  // stop sending and wait until every owed color has come back
  task automatic drain();
    joy_bus.valid <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
  endtask

  task automatic write_saturation(logic [SAT_W-1:0] value);
    cfg_bus.valid      <= 1'b1;
    cfg_bus.saturation <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    tracker.set_saturation(value);
    cfg_bus.valid <= 1'b0;
  endtask

  // run limit
  initial begin
    #10_000_000;
    $display("joystick_hsv_to_rgb_led_color test failed");
    $finish;
  end

  initial begin
    logic [SAT_W-1:0]   phase_sat [NUM_PHASES];
    logic [DT_W-1:0]    dt;
    logic [STICK_W-1:0] sx, sy;
    int                 mode;
    tracker = new();
    phase_sat = '{9'd0, 9'd511, 9'd128, 9'd257, 9'd1, 9'd255, 9'd256, 9'd0};
    rst                <= 1'b1;
    joy_bus.valid      <= 1'b0;
    joy_bus.elapsed_ms <= '0;
    joy_bus.stick_x    <= '0;
    joy_bus.stick_y    <= '0;
    cfg_bus.valid      <= 1'b0;
    cfg_bus.saturation <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed words at reset saturation
    send_word(16'd0, 10'd512, 10'd512);      // reset color
    send_word(16'd1, 10'd441, 10'd583);      // both just inside deadzone
    send_word(16'd1, 10'd584, 10'd512);      // smallest counted hue step up
    send_word(16'd1, 10'd440, 10'd512);      // and down
    send_word(16'd1, 10'd512, 10'd584);      // smallest brightness drop
    send_word(16'd1, 10'd512, 10'd440);      // smallest brightness rise
    send_word(16'd65535, 10'd1023, 10'd0);   // hue overflow, brightness to full
    send_word(16'd240, 10'd768, 10'd512);    // onto a sector boundary
    send_word(16'd240, 10'd768, 10'd512);
    send_word(16'd65535, 10'd0, 10'd512);    // hue below zero
    send_word(16'd720, 10'd1023, 10'd512);   // into the last sector
    send_word(16'd10, 10'd584, 10'd512);     // hue lands exactly on 360 degrees
    send_word(16'd65535, 10'd512, 10'd1023); // brightness to zero
    send_word(16'd720, 10'd512, 10'd0);      // brightness exactly full
    send_word(16'd100, 10'd900, 10'd512);
    send_word(16'd0, 10'd1023, 10'd1023);    // no time, no step
    send_word(16'd65535, 10'd512, 10'd512);  // centered sticks
    send_word(16'd300, 10'd1023, 10'd700);
    send_word(16'd200, 10'd1023, 10'd512);
    send_word(16'd150, 10'd1023, 10'd512);
    send_word(16'd120, 10'd0, 10'd300);
    send_word(16'd1, 10'd0, 10'd1023);

    // random phases, one saturation each; the last one without idling
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      if (p == NUM_PHASES - 1) begin
        idle_enable = 1'b0;
        phase_sat[p] = SAT_W'($urandom_range(0, 511));
      end
      write_saturation(phase_sat[p]);
      for (int i = 0; i < PHASE_WORDS; i++) begin
        mode = $urandom_range(0, 99);
        if (mode < 65) begin
          // steady steering: hue drifts around, brightness wanders
          dt = DT_W'($urandom_range(1, 100));
          sx = STICK_W'($urandom_range(0, 1) ? STICK_MID + $urandom_range(0, 511)
                                             : STICK_MID - $urandom_range(0, 511));
          sy = STICK_W'($urandom_range(0, 1) ? STICK_MID + $urandom_range(0, 200)
                                             : STICK_MID - $urandom_range(0, 200));
        end else if (mode < 82) begin
          // around the deadzone edge
          dt = DT_W'($urandom_range(0, 3));
          sx = STICK_W'($urandom_range(0, 1) ? STICK_MID + $urandom_range(0, 80)
                                             : STICK_MID - $urandom_range(0, 80));
          sy = STICK_W'($urandom_range(0, 1) ? STICK_MID + $urandom_range(0, 80)
                                             : STICK_MID - $urandom_range(0, 80));
        end else if (mode < 92) begin
          dt = DT_W'($urandom);
          sx = STICK_W'($urandom);
          sy = STICK_W'($urandom);
        end else begin
          // one or both sticks centered
          dt = DT_W'($urandom);
          sx = $urandom_range(0, 1) ? STICK_W'(STICK_MID) : STICK_W'($urandom);
          sy = STICK_W'(STICK_MID);
        end
        send_word(dt, sx, sy);
        if (i == PHASE_WORDS / 2)
          drain();
      end
    end

    // wait out everything owed plus the block's latency
    drain();
    repeat (24) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending() == 0)
      $display("joystick_hsv_to_rgb_led_color test passed");
    else
      $display("joystick_hsv_to_rgb_led_color test failed");
    $finish;
  end

endmodule
